### rtl/pcis_pkg.sv
// ----------------------------------------------------------------------------
// PCIS package
// Shared types, register indexes, constants and saturation helpers for the
// clamped PID controller with integral separation.
// ----------------------------------------------------------------------------
package pcis_pkg;

    localparam int unsigned GAIN_W  = 24;
    localparam int unsigned LIMIT_W = 31;
    localparam int unsigned MODE_W  = 4;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned WIDE_W  = 34;
    localparam int unsigned ADDR_W  = 3;

    // Bit positions inside mode_bits.
    localparam int unsigned MODE_ERR_CLAMP = 0;
    localparam int unsigned MODE_INT_CLAMP = 1;
    localparam int unsigned MODE_SEPARATE  = 2;
    localparam int unsigned MODE_WRAP      = 3;

    // 180.0 and 360.0 in Q16.16.
    localparam logic signed [WIDE_W-1:0] WRAP_HALF = 34'sd11796480;
    localparam logic signed [WIDE_W-1:0] WRAP_FULL = 34'sd23592960;

    typedef enum logic [ADDR_W-1:0] {
        REG_GAIN_P          = 3'd0,
        REG_GAIN_I          = 3'd1,
        REG_GAIN_D          = 3'd2,
        REG_ERROR_LIMIT     = 3'd3,
        REG_SEPARATION_BAND = 3'd4,
        REG_INTEGRAL_LIMIT  = 3'd5,
        REG_OUTPUT_LIMIT    = 3'd6,
        REG_MODE_BITS       = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic [LIMIT_W-1:0] error_limit;
        logic [LIMIT_W-1:0] separation_band;
        logic [LIMIT_W-1:0] integral_limit;
        logic [LIMIT_W-1:0] output_limit;
        logic [MODE_W-1:0]  mode_bits;
    } cfg_t;

    // Saturate a 34-bit signed value to the 32-bit signed range.
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 34'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -34'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // Symmetric clamp: the upper bound is applied first, then the lower one.
    function automatic logic signed [WIDE_W-1:0] clamp_sym(
        input logic signed [WIDE_W-1:0] v,
        input logic [LIMIT_W-1:0]       lim
    );
        logic signed [WIDE_W-1:0] l;
        logic signed [WIDE_W-1:0] r;
        l = $signed({3'b000, lim});
        r = v;
        if (r >= l) begin
            r = l;
        end
        if (r <= -l) begin
            r = -l;
        end
        return r;
    endfunction

endpackage

### rtl/pcis_cfg_regs.sv
// ----------------------------------------------------------------------------
// PCIS configuration registers
// Holds the gains, limits and mode bits written through the plain write port.
// ----------------------------------------------------------------------------
module pcis_cfg_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [pcis_pkg::ADDR_W-1:0]  cfg_addr,
    input  logic [pcis_pkg::LIMIT_W-1:0] cfg_wdata,
    output pcis_pkg::cfg_t               cfg
);

    pcis_pkg::cfg_t cfg_reg;
    pcis_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (pcis_pkg::reg_idx_t'(cfg_addr))
                pcis_pkg::REG_GAIN_P:          cfg_next.gain_p = cfg_wdata[pcis_pkg::GAIN_W-1:0];
                pcis_pkg::REG_GAIN_I:          cfg_next.gain_i = cfg_wdata[pcis_pkg::GAIN_W-1:0];
                pcis_pkg::REG_GAIN_D:          cfg_next.gain_d = cfg_wdata[pcis_pkg::GAIN_W-1:0];
                pcis_pkg::REG_ERROR_LIMIT:     cfg_next.error_limit = cfg_wdata;
                pcis_pkg::REG_SEPARATION_BAND: cfg_next.separation_band = cfg_wdata;
                pcis_pkg::REG_INTEGRAL_LIMIT:  cfg_next.integral_limit = cfg_wdata;
                pcis_pkg::REG_OUTPUT_LIMIT:    cfg_next.output_limit = cfg_wdata;
                pcis_pkg::REG_MODE_BITS:       cfg_next.mode_bits = cfg_wdata[pcis_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/pcis_gain_mul.sv
// ----------------------------------------------------------------------------
// PCIS gain multiplier
// Unsigned Q8.16 gain times a signed Q17.16 value, rounded half up back to
// Q16.16 and saturated to 32 bits.
// ----------------------------------------------------------------------------
module pcis_gain_mul (
    input  logic [pcis_pkg::GAIN_W-1:0]        gain,
    input  logic signed [pcis_pkg::DATA_W:0]   x,
    output logic signed [pcis_pkg::DATA_W-1:0] y
);

    localparam int unsigned PROD_W = pcis_pkg::GAIN_W + pcis_pkg::DATA_W + 2;
    localparam int unsigned Q_W    = PROD_W - 16;

    logic signed [pcis_pkg::GAIN_W:0] gain_s;
    logic signed [PROD_W-1:0]         prod;
    logic signed [PROD_W-1:0]         rnd;
    logic signed [Q_W-1:0]            q;
    logic                             fits;

    assign gain_s = $signed({1'b0, gain});
    assign prod   = PROD_W'(gain_s) * PROD_W'(x);
    assign rnd    = prod + PROD_W'(32768);
    // Dropping the low 16 bits of a two's complement value is a floor.
    assign q      = rnd[PROD_W-1:16];

    // The value fits when bit 31 and every bit above it match the sign bit.
    assign fits = (q[Q_W-1:pcis_pkg::DATA_W-1] == '0) || (q[Q_W-1:pcis_pkg::DATA_W-1] == '1);

    always_comb begin
        if (fits) begin
            y = q[pcis_pkg::DATA_W-1:0];
        end else if (q[Q_W-1]) begin
            y = 32'sh8000_0000;
        end else begin
            y = 32'sh7FFF_FFFF;
        end
    end

endmodule

### rtl/pcis_step.sv
// ----------------------------------------------------------------------------
// PCIS step datapath
// Error forming, wrap and clamp, gated integral update and the drive sum for
// one request, given the current controller state.
// ----------------------------------------------------------------------------
module pcis_step (
    input  pcis_pkg::cfg_t                     cfg,
    input  logic signed [pcis_pkg::DATA_W-1:0] setpoint,
    input  logic signed [pcis_pkg::DATA_W-1:0] trim,
    input  logic signed [pcis_pkg::DATA_W-1:0] measured,
    input  logic signed [pcis_pkg::DATA_W-1:0] prev_error,
    input  logic signed [pcis_pkg::DATA_W-1:0] integral_acc,
    output logic signed [pcis_pkg::DATA_W-1:0] error_out,
    output logic signed [pcis_pkg::DATA_W-1:0] integral_out,
    output logic signed [pcis_pkg::DATA_W-1:0] drive
);

    localparam int unsigned WW = pcis_pkg::WIDE_W;
    localparam int unsigned DW = pcis_pkg::DATA_W;

    logic signed [WW-1:0] err_raw;
    logic signed [WW-1:0] err_wrap;
    logic signed [WW-1:0] err_clamp;
    logic signed [DW-1:0] err;
    logic signed [DW:0]   err_ext;
    logic signed [DW:0]   err_diff;
    logic [DW:0]          err_mag;
    logic                 integrate;
    logic signed [DW-1:0] i_term;
    logic signed [DW-1:0] p_term;
    logic signed [DW-1:0] d_term;
    logic signed [DW-1:0] integ_sum;
    logic signed [DW-1:0] integ_gated;
    logic signed [WW-1:0] integ_clamp;
    logic signed [WW-1:0] drive_sum;
    logic signed [WW-1:0] drive_clamp;

    assign err_raw = WW'(setpoint) + WW'(trim) - WW'(measured);

    // A single correction toward the +-180.0 window when the wrap mode bit is set.
    always_comb begin
        err_wrap = err_raw;
        if (cfg.mode_bits[pcis_pkg::MODE_WRAP]) begin
            if (err_raw < -pcis_pkg::WRAP_HALF) begin
                err_wrap = err_raw + pcis_pkg::WRAP_FULL;
            end else if (err_raw > pcis_pkg::WRAP_HALF) begin
                err_wrap = err_raw - pcis_pkg::WRAP_FULL;
            end
        end
    end

    assign err_clamp = cfg.mode_bits[pcis_pkg::MODE_ERR_CLAMP]
                     ? pcis_pkg::clamp_sym(err_wrap, cfg.error_limit) : err_wrap;
    assign err       = pcis_pkg::sat32(err_clamp);
    assign err_ext   = (DW + 1)'(err);
    assign err_diff  = err_ext - (DW + 1)'(prev_error);
    assign err_mag   = err_ext[DW] ? unsigned'(-err_ext) : unsigned'(err_ext);

    assign integrate = !cfg.mode_bits[pcis_pkg::MODE_SEPARATE]
                     || (err_mag <= (DW + 1)'(cfg.separation_band));

    pcis_gain_mul u_mul_i (.gain(cfg.gain_i), .x(err_ext),  .y(i_term));
    pcis_gain_mul u_mul_p (.gain(cfg.gain_p), .x(err_ext),  .y(p_term));
    pcis_gain_mul u_mul_d (.gain(cfg.gain_d), .x(err_diff), .y(d_term));

    assign integ_sum   = pcis_pkg::sat32(WW'(integral_acc) + WW'(i_term));
    assign integ_gated = integrate ? integ_sum : integral_acc;
    assign integ_clamp = cfg.mode_bits[pcis_pkg::MODE_INT_CLAMP]
                       ? pcis_pkg::clamp_sym(WW'(integ_gated), cfg.integral_limit)
                       : WW'(integ_gated);

    assign drive_sum   = WW'(p_term) + integ_clamp + WW'(d_term);
    assign drive_clamp = pcis_pkg::clamp_sym(drive_sum, cfg.output_limit);

    assign error_out    = err;
    assign integral_out = integ_clamp[DW-1:0];
    assign drive        = drive_clamp[DW-1:0];

endmodule

### rtl/pid_clamped_integral_separation.sv
// A request accepted into the input register is written into the result register, and so
// onto m_tdata, once the result register is free or drains.
// Throughput: one request per cycle unless a full result register is stalled by m_tready;
// error and integral state update with each result write, so back-to-back requests chain.
// Reset (aresetn low at a clock edge) clears the gains, limits, mode bits, the
// previous error and the integral, and empties both pipeline registers.
// ----------------------------------------------------------------------------
// Clamped PID controller with integral separation
// Stream in (setpoint, trim, measured), stream out (drive, integral_now).
// ----------------------------------------------------------------------------
module pid_clamped_integral_separation (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [pcis_pkg::ADDR_W-1:0]  cfg_addr,
    input  logic [pcis_pkg::LIMIT_W-1:0] cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // s_tdata fields from bit 0: setpoint[31:0], trim[63:32], measured[95:64]
    input  logic [95:0]                  s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // m_tdata fields from bit 0: drive[31:0], integral_now[63:32]
    output logic [63:0]                  m_tdata
);

    localparam int unsigned DW = pcis_pkg::DATA_W;

    pcis_pkg::cfg_t cfg;

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [3*DW-1:0]      in_data_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [2*DW-1:0]      out_data_reg;
    logic signed [DW-1:0] prev_error_reg;
    logic signed [DW-1:0] integral_acc_reg;

    logic                 advance;
    logic                 s_accept;
    logic signed [DW-1:0] error_new;
    logic signed [DW-1:0] integral_new;
    logic signed [DW-1:0] drive_new;

    pcis_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pcis_step u_step (
        .cfg          (cfg),
        .setpoint     (in_data_reg[DW-1:0]),
        .trim         (in_data_reg[2*DW-1:DW]),
        .measured     (in_data_reg[3*DW-1:2*DW]),
        .prev_error   (prev_error_reg),
        .integral_acc (integral_acc_reg),
        .error_out    (error_new),
        .integral_out (integral_new),
        .drive        (drive_new)
    );

    // The input register moves on whenever the result register is free or drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            prev_error_reg   <= '0;
            integral_acc_reg <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                prev_error_reg   <= error_new;
                integral_acc_reg <= integral_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg <= s_tdata;
        end
        if (advance) begin
            out_data_reg <= {integral_new, drive_new};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### rtl/pcis_checker.sv
// ----------------------------------------------------------------------------
// PCIS port checker
// Watches the top level ports for reset, stall and output range behavior.
// ----------------------------------------------------------------------------
module pcis_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         cfg_we,
    input logic [pcis_pkg::ADDR_W-1:0]  cfg_addr,
    input logic [pcis_pkg::LIMIT_W-1:0] cfg_wdata,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [95:0]                  s_tdata,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [63:0]                  m_tdata
);

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // With the result register empty the pipeline can always take a request.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("request refused with empty result register");

    // The drive clamp is symmetric, so the most negative code never appears.
    a_drive_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:0] != 32'h8000_0000)
        else $error("drive outside the symmetric clamp range");

endmodule

bind pid_clamped_integral_separation pcis_checker u_pcis_checker (.*);
